[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions in the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define CHK_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds while reset is high.
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hbns_pkg.sv]
// ----------------------------------------------------------------------------
// hbns_pkg
// Types and constants shared by the heightmap sampler modules.
// ----------------------------------------------------------------------------
package hbns_pkg;

  localparam int GRID_W      = 8;
  localparam int GRID_SIDE   = 1 << GRID_W;
  localparam int ADDR_W      = 2 * GRID_W;
  localparam int HEIGHT_BITS = 24;
  localparam int NPTS_W      = 9;
  localparam int WS_W        = 23;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 23;

  localparam int HFRAC = 12;
  localparam int SFRAC = 16;
  localparam int NFRAC = 14;

  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
  localparam int SQ_RAD_W  = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_HEIGHT  = 2'd1;
  localparam logic [1:0] CMD_NORMAL  = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_Z     = 2'd2;

  localparam logic [NPTS_W-1:0] GRID_POINTS_RST = 9'd256;
  localparam logic [WS_W-1:0]   WORLD_SIZE_RST  = 23'd65280;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [SQ_RAD_W-1:0] rad;
  } sq_req_t;

  typedef struct packed {
    logic                 done;
    logic [SQ_ROOT_W-1:0] root;
  } sq_rsp_t;

endpackage

[hw/rtl/hbns_in_if.sv]
// ----------------------------------------------------------------------------
// hbns_in_if
// Command channel: valid, ready and one command item.
// ----------------------------------------------------------------------------
interface hbns_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_z;
  logic [7:0]        cell_x;
  logic [7:0]        cell_z;
  logic signed [23:0] height_in;

  modport source (output valid, command, pos_x, pos_z, cell_x, cell_z, height_in,
                  input ready);
  modport sink (input valid, command, pos_x, pos_z, cell_x, cell_z, height_in,
                output ready);
endinterface

[hw/rtl/hbns_out_if.sv]
// ----------------------------------------------------------------------------
// hbns_out_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface hbns_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               accepted;
  logic signed [23:0] height_out;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;

  modport source (output valid, kind, accepted, height_out, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, kind, accepted, height_out, normal_x, normal_y, normal_z,
                output ready);
endinterface

[hw/rtl/hbns_ram.sv]
// ----------------------------------------------------------------------------
// hbns_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hbns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/hbns_div.sv]
// ----------------------------------------------------------------------------
// hbns_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbns_div (
  input  logic               clk,
  input  logic               rst,
  input  hbns_pkg::div_req_t req,
  output hbns_pkg::div_rsp_t rsp
);

  logic [hbns_pkg::DIV_NUM_W-1:0] num_sh;
  logic [hbns_pkg::DIV_DEN_W-1:0] den;
  logic [hbns_pkg::DIV_DEN_W-1:0] rem;
  logic [hbns_pkg::DIV_DEN_W:0]   rem_sh;
  logic [hbns_pkg::DIV_DEN_W-1:0] rem_next;
  logic [hbns_pkg::DIV_CNT_W-1:0] cnt;
  logic                           fits;
  logic                           busy;
  logic                           done;

  always_comb begin
    rem_sh = {rem, num_sh[hbns_pkg::DIV_NUM_W-1]};
    fits   = rem_sh >= {1'b0, den};
    if (fits) begin
      rem_next = hbns_pkg::DIV_DEN_W'(rem_sh - {1'b0, den});
    end else begin
      rem_next = rem_sh[hbns_pkg::DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= hbns_pkg::DIV_CNT_W'(hbns_pkg::DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == hbns_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den    <= req.den;
      rem    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[hbns_pkg::DIV_NUM_W-2:0], fits};
      rem    <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num_sh;

endmodule

[hw/rtl/hbns_sqrt.sv]
// ----------------------------------------------------------------------------
// hbns_sqrt
// Integer square root, floor, one root bit per cycle.
// ----------------------------------------------------------------------------
module hbns_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  hbns_pkg::sq_req_t req,
  output hbns_pkg::sq_rsp_t rsp
);

  logic [hbns_pkg::SQ_RAD_W-1:0]  rad_sh;
  logic [hbns_pkg::SQ_ROOT_W-1:0] root;
  logic [hbns_pkg::SQ_ROOT_W:0]   rem;
  logic [hbns_pkg::SQ_ROOT_W+2:0] rem_sh;
  logic [hbns_pkg::SQ_ROOT_W+2:0] trial;
  logic [hbns_pkg::SQ_CNT_W-1:0]  cnt;
  logic                           fits;
  logic                           busy;
  logic                           done;

  always_comb begin
    rem_sh = {rem, rad_sh[hbns_pkg::SQ_RAD_W-1:hbns_pkg::SQ_RAD_W-2]};
    trial  = {1'b0, root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= hbns_pkg::SQ_CNT_W'(hbns_pkg::SQ_ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == hbns_pkg::SQ_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_sh <= req.rad;
      root   <= '0;
      rem    <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[hbns_pkg::SQ_RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= (hbns_pkg::SQ_ROOT_W+1)'(rem_sh - trial);
        root <= {root[hbns_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[hbns_pkg::SQ_ROOT_W:0];
        root <= {root[hbns_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

[hw/rtl/heightmap_bilinear_normal_sampler_unit.sv]
// ----------------------------------------------------------------------------
// heightmap_bilinear_normal_sampler_unit: one command at a time; a write goes through the done state to the result.
// Height query: two divides, four fetches, six multiply steps.
// Normal query: four fetches, five divides on the shared divider, and a square root.
// Synchronous reset restores the configuration and control registers; the height store is not cleared.
// ----------------------------------------------------------------------------
module heightmap_bilinear_normal_sampler_unit (
  input  logic                                clk,
  input  logic                                rst,
  hbns_in_if.sink                             in_ch,
  hbns_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [hbns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hbns_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HDIV  = 5'd1;
  localparam logic [4:0] S_HWAIT = 5'd2;
  localparam logic [4:0] S_FADDR = 5'd3;
  localparam logic [4:0] S_FDATA = 5'd4;
  localparam logic [4:0] S_B0    = 5'd5;
  localparam logic [4:0] S_B1    = 5'd6;
  localparam logic [4:0] S_B2    = 5'd7;
  localparam logic [4:0] S_B3    = 5'd8;
  localparam logic [4:0] S_B4    = 5'd9;
  localparam logic [4:0] S_B5    = 5'd10;
  localparam logic [4:0] S_NDIV  = 5'd11;
  localparam logic [4:0] S_NWAIT = 5'd12;
  localparam logic [4:0] S_NORM  = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_SQS   = 5'd15;
  localparam logic [4:0] S_SQW   = 5'd16;
  localparam logic [4:0] S_ODIV  = 5'd17;
  localparam logic [4:0] S_OWAIT = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  localparam int GC_W = hbns_pkg::GRID_W + hbns_pkg::HFRAC;
  localparam int W_W  = hbns_pkg::HFRAC + 1;
  localparam int V_W  = hbns_pkg::DIV_NUM_W + 1;

  function automatic logic [hbns_pkg::GRID_W-1:0] clampc(
    input logic signed [hbns_pkg::GRID_W+1:0] v,
    input logic [hbns_pkg::GRID_W-1:0]        hi
  );
    logic [hbns_pkg::GRID_W-1:0] r;
    if (v[hbns_pkg::GRID_W+1]) begin
      r = '0;
    end else if (v[hbns_pkg::GRID_W:0] > {1'b0, hi}) begin
      r = hi;
    end else begin
      r = v[hbns_pkg::GRID_W-1:0];
    end
    return r;
  endfunction

  logic [hbns_pkg::NPTS_W-1:0] grid_points;
  logic [hbns_pkg::WS_W-1:0]   world_size_x;
  logic [hbns_pkg::WS_W-1:0]   world_size_z;

  logic [4:0]  state;
  logic        axis;
  logic [1:0]  k;
  logic [1:0]  cmd;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_z;
  logic [7:0]  cx;
  logic [7:0]  cz;
  logic        res_acc;
  logic [GC_W-1:0] gx;
  logic [GC_W-1:0] gz;
  logic signed [hbns_pkg::HEIGHT_BITS-1:0] hs [4];
  logic [V_W-1:0]  vm [3];
  logic [61:0] sumsq;
  logic [hbns_pkg::SQ_ROOT_W-1:0] root;
  logic [hbns_pkg::NFRAC:0] onrm [3];
  logic signed [37:0] r_acc;
  logic signed [37:0] r0;
  logic signed [51:0] acc;
  logic signed [23:0] res_height;

  logic [hbns_pkg::NPTS_W-1:0] n_eff;
  logic [hbns_pkg::GRID_W-1:0] nm1;
  logic [hbns_pkg::WS_W-1:0]   wsx;
  logic [hbns_pkg::WS_W-1:0]   wsz;
  logic [hbns_pkg::WS_W-1:0]   wsel;
  logic in_acc;
  logic out_load;
  logic wr_ok;

  logic signed [23:0] psel;
  logic signed [25:0] hsum;
  logic [32:0] hprod;
  logic [hbns_pkg::DIV_NUM_W-1:0] hnum;
  logic [GC_W-1:0] gsat;

  logic signed [24:0] dx;
  logic signed [24:0] dz;
  logic signed [24:0] dsel;
  logic [24:0] amag;
  logic [31:0] sprod;
  logic [hbns_pkg::DIV_NUM_W-1:0] snum;
  logic [V_W-1:0] vmax;

  logic [7:0] x0;
  logic [7:0] z0;
  logic [7:0] x1;
  logic [7:0] z1;
  logic [7:0] fx;
  logic [7:0] fz;
  logic [W_W-1:0] wx0;
  logic [W_W-1:0] wz0;

  logic signed [23:0] mul_h;
  logic signed [W_W:0] mul_w;
  logic signed [37:0] mul_a;
  logic signed [37:0] mul_r;
  logic signed [W_W:0] mul_wz;
  logic signed [51:0] mul_b;
  logic signed [51:0] s_sum;
  logic signed [27:0] h_full;
  logic signed [23:0] h_sat;
  logic [59:0] sq;

  logic [15:0] nx_mag;
  logic [15:0] nz_mag;

  hbns_pkg::div_req_t div_req;
  hbns_pkg::div_rsp_t div_rsp;
  hbns_pkg::sq_req_t  sq_req;
  hbns_pkg::sq_rsp_t  sq_rsp;

  logic                              ram_we;
  logic [hbns_pkg::ADDR_W-1:0]       ram_raddr;
  logic [hbns_pkg::HEIGHT_BITS-1:0]  ram_rdata;

  always_comb begin
    if (grid_points < hbns_pkg::NPTS_W'(2)) begin
      n_eff = hbns_pkg::NPTS_W'(2);
    end else if (grid_points > hbns_pkg::NPTS_W'(hbns_pkg::GRID_SIDE)) begin
      n_eff = hbns_pkg::NPTS_W'(hbns_pkg::GRID_SIDE);
    end else begin
      n_eff = grid_points;
    end
    nm1 = hbns_pkg::GRID_W'(n_eff - 1'b1);
    wsx = (world_size_x == '0) ? hbns_pkg::WS_W'(1) : world_size_x;
    wsz = (world_size_z == '0) ? hbns_pkg::WS_W'(1) : world_size_z;
    wsel = axis ? wsz : wsx;
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state == S_DONE) && (!out_ch.valid || out_ch.ready);
  assign wr_ok       = ({1'b0, in_ch.cell_x} < n_eff) && ({1'b0, in_ch.cell_z} < n_eff);
  assign ram_we      = in_acc && (in_ch.command == hbns_pkg::CMD_WRITE) && wr_ok;

  // Height query: grid coordinate numerator, zero when not positive.
  always_comb begin
    psel  = axis ? pos_z : pos_x;
    hsum  = $signed({psel[23], psel, 1'b0}) + $signed({3'b000, wsel});
    hprod = hsum[24:0] * nm1;
    if (!hsum[25] && (hsum != '0)) begin
      hnum = {3'b000, hprod, {hbns_pkg::HFRAC{1'b0}}};
    end else begin
      hnum = '0;
    end
    if (div_rsp.quot > hbns_pkg::DIV_NUM_W'({nm1, {hbns_pkg::HFRAC{1'b0}}})) begin
      gsat = {nm1, {hbns_pkg::HFRAC{1'b0}}};
    end else begin
      gsat = div_rsp.quot[GC_W-1:0];
    end
  end

  // Normal query: slope numerators and normalization.
  always_comb begin
    dx    = 25'(hs[0]) - 25'(hs[1]);
    dz    = 25'(hs[2]) - 25'(hs[3]);
    dsel  = axis ? dz : dx;
    amag  = dsel[24] ? 25'(-dsel) : 25'(dsel);
    sprod = amag[23:0] * nm1;
    snum  = {sprod, {hbns_pkg::SFRAC{1'b0}}} + hbns_pkg::DIV_NUM_W'(wsel[hbns_pkg::WS_W-1:1]);
    vmax  = vm[0];
    if (vm[1] > vmax) begin
      vmax = vm[1];
    end
    if (vm[2] > vmax) begin
      vmax = vm[2];
    end
    sq = vm[k][29:0] * vm[k][29:0];
  end

  always_comb begin
    div_req.start = (state == S_HDIV) || (state == S_NDIV) || (state == S_ODIV);
    unique case (state)
      S_HDIV: begin
        div_req.num = hnum;
        div_req.den = hbns_pkg::DIV_DEN_W'({wsel, 1'b0});
      end
      S_NDIV: begin
        div_req.num = snum;
        div_req.den = hbns_pkg::DIV_DEN_W'(wsel);
      end
      default: begin
        div_req.num = {4'b0000, vm[k][29:0], {hbns_pkg::NFRAC{1'b0}}}
                      + hbns_pkg::DIV_NUM_W'(root[hbns_pkg::SQ_ROOT_W-1:1]);
        div_req.den = root;
      end
    endcase
    sq_req.start = (state == S_SQS);
    sq_req.rad   = {2'b00, sumsq};
  end

  // Fetch addresses, clamped to the grid in use.
  always_comb begin
    x0  = gx[GC_W-1:hbns_pkg::HFRAC];
    z0  = gz[GC_W-1:hbns_pkg::HFRAC];
    x1  = (x0 == nm1) ? nm1 : 8'(x0 + 1'b1);
    z1  = (z0 == nm1) ? nm1 : 8'(z0 + 1'b1);
    wx0 = W_W'(1 << hbns_pkg::HFRAC) - {1'b0, gx[hbns_pkg::HFRAC-1:0]};
    wz0 = W_W'(1 << hbns_pkg::HFRAC) - {1'b0, gz[hbns_pkg::HFRAC-1:0]};
    if (cmd == hbns_pkg::CMD_HEIGHT) begin
      fx = k[0] ? x1 : x0;
      fz = k[1] ? z1 : z0;
    end else begin
      unique case (k)
        2'd0: begin
          fx = clampc($signed({2'b00, cx}) + 10'sd2, nm1);
          fz = clampc($signed({2'b00, cz}), nm1);
        end
        2'd1: begin
          fx = clampc($signed({2'b00, cx}) - 10'sd2, nm1);
          fz = clampc($signed({2'b00, cz}), nm1);
        end
        2'd2: begin
          fx = clampc($signed({2'b00, cx}), nm1);
          fz = clampc($signed({2'b00, cz}) + 10'sd2, nm1);
        end
        default: begin
          fx = clampc($signed({2'b00, cx}), nm1);
          fz = clampc($signed({2'b00, cz}) - 10'sd2, nm1);
        end
      endcase
    end
    ram_raddr = {fz, fx};
  end

  // Bilinear multiply steps.
  always_comb begin
    unique case (state)
      S_B0: begin
        mul_h = hs[0];
        mul_w = $signed({1'b0, wx0});
      end
      S_B1: begin
        mul_h = hs[1];
        mul_w = $signed({2'b00, gx[hbns_pkg::HFRAC-1:0]});
      end
      S_B2: begin
        mul_h = hs[2];
        mul_w = $signed({1'b0, wx0});
      end
      default: begin
        mul_h = hs[3];
        mul_w = $signed({2'b00, gx[hbns_pkg::HFRAC-1:0]});
      end
    endcase
    mul_a = mul_h * mul_w;
    if (state == S_B4) begin
      mul_r  = r0;
      mul_wz = $signed({1'b0, wz0});
    end else begin
      mul_r  = r_acc;
      mul_wz = $signed({2'b00, gz[hbns_pkg::HFRAC-1:0]});
    end
    mul_b  = mul_r * mul_wz;
    s_sum  = acc + mul_b + (52'sd1 <<< (2 * hbns_pkg::HFRAC - 1));
    h_full = s_sum[51:2*hbns_pkg::HFRAC];
    if (h_full > 28'sd8388607) begin
      h_sat = 24'sd8388607;
    end else if (h_full < -28'sd8388608) begin
      h_sat = -24'sd8388608;
    end else begin
      h_sat = h_full[23:0];
    end
  end

  always_comb begin
    nx_mag = {1'b0, onrm[0]};
    nz_mag = {1'b0, onrm[2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_points  <= hbns_pkg::GRID_POINTS_RST;
      world_size_x <= hbns_pkg::WORLD_SIZE_RST;
      world_size_z <= hbns_pkg::WORLD_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbns_pkg::CFG_GRID_POINTS: grid_points  <= cfg_data[hbns_pkg::NPTS_W-1:0];
        hbns_pkg::CFG_WORLD_X:     world_size_x <= cfg_data[hbns_pkg::WS_W-1:0];
        hbns_pkg::CFG_WORLD_Z:     world_size_z <= cfg_data[hbns_pkg::WS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      axis         <= 1'b0;
      k            <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            axis <= 1'b0;
            k    <= '0;
            if (in_ch.command == hbns_pkg::CMD_HEIGHT) begin
              state <= S_HDIV;
            end else if (in_ch.command == hbns_pkg::CMD_NORMAL) begin
              state <= S_FADDR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_HDIV:  state <= S_HWAIT;
        S_HWAIT: begin
          if (div_rsp.done) begin
            if (!axis) begin
              axis  <= 1'b1;
              state <= S_HDIV;
            end else begin
              k     <= '0;
              state <= S_FADDR;
            end
          end
        end
        S_FADDR: state <= S_FDATA;
        S_FDATA: begin
          k <= k + 1'b1;
          if (k == 2'd3) begin
            axis  <= 1'b0;
            state <= (cmd == hbns_pkg::CMD_HEIGHT) ? S_B0 : S_NDIV;
          end else begin
            state <= S_FADDR;
          end
        end
        S_B0:    state <= S_B1;
        S_B1:    state <= S_B2;
        S_B2:    state <= S_B3;
        S_B3:    state <= S_B4;
        S_B4:    state <= S_B5;
        S_B5:    state <= S_DONE;
        S_NDIV:  state <= S_NWAIT;
        S_NWAIT: begin
          if (div_rsp.done) begin
            if (!axis) begin
              axis  <= 1'b1;
              state <= S_NDIV;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if ((vmax[V_W-1:30] == '0) && vmax[29]) begin
            k     <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (k == 2'd2) begin
            state <= S_SQS;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SQS:   state <= S_SQW;
        S_SQW: begin
          if (sq_rsp.done) begin
            k     <= '0;
            state <= S_ODIV;
          end
        end
        S_ODIV:  state <= S_OWAIT;
        S_OWAIT: begin
          if (div_rsp.done) begin
            if (k == 2'd2) begin
              state <= S_DONE;
            end else begin
              k     <= k + 1'b1;
              state <= S_ODIV;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd        <= in_ch.command;
      pos_x      <= in_ch.pos_x;
      pos_z      <= in_ch.pos_z;
      cx         <= in_ch.cell_x;
      cz         <= in_ch.cell_z;
      res_height <= '0;
      if (in_ch.command == hbns_pkg::CMD_WRITE) begin
        res_acc <= wr_ok;
      end else begin
        res_acc <= (in_ch.command == hbns_pkg::CMD_HEIGHT)
                   || (in_ch.command == hbns_pkg::CMD_NORMAL);
      end
    end
    if ((state == S_HWAIT) && div_rsp.done) begin
      if (!axis) begin
        gx <= gsat;
      end else begin
        gz <= gsat;
      end
    end
    if (state == S_FDATA) begin
      hs[k] <= ram_rdata;
    end
    unique case (state)
      S_B0, S_B2: r_acc <= mul_a;
      S_B1:       r0    <= r_acc + mul_a;
      S_B3:       r_acc <= r_acc + mul_a;
      S_B4:       acc   <= mul_b;
      S_B5:       res_height <= h_sat;
      default: begin
      end
    endcase
    if ((state == S_NWAIT) && div_rsp.done) begin
      if (!axis) begin
        vm[0] <= {1'b0, div_rsp.quot};
      end else begin
        vm[2] <= {1'b0, div_rsp.quot};
        vm[1] <= V_W'(4 << hbns_pkg::SFRAC);
      end
    end
    if (state == S_NORM) begin
      if (vmax[V_W-1:30] != '0) begin
        for (int i = 0; i < 3; i++) begin
          vm[i] <= vm[i] >> 1;
        end
      end else if (!vmax[29]) begin
        for (int i = 0; i < 3; i++) begin
          vm[i] <= vm[i] << 1;
        end
      end
      sumsq <= '0;
    end
    if (state == S_SQ) begin
      sumsq <= sumsq + 62'(sq);
    end
    if ((state == S_SQW) && sq_rsp.done) begin
      root <= sq_rsp.root;
    end
    if ((state == S_OWAIT) && div_rsp.done) begin
      onrm[k] <= div_rsp.quot[hbns_pkg::NFRAC:0];
    end
    if (out_load) begin
      out_ch.kind       <= cmd;
      out_ch.accepted   <= res_acc;
      out_ch.height_out <= (cmd == hbns_pkg::CMD_HEIGHT) ? res_height : '0;
      if (cmd == hbns_pkg::CMD_NORMAL) begin
        out_ch.normal_x <= (!dx[24] && (dx != '0)) ? $signed(16'(0) - nx_mag)
                                                   : $signed(nx_mag);
        out_ch.normal_y <= $signed({1'b0, onrm[1]});
        out_ch.normal_z <= (!dz[24] && (dz != '0)) ? $signed(16'(0) - nz_mag)
                                                   : $signed(nz_mag);
      end else begin
        out_ch.normal_x <= '0;
        out_ch.normal_y <= '0;
        out_ch.normal_z <= '0;
      end
    end
  end

  hbns_ram #(
    .WIDTH(hbns_pkg::HEIGHT_BITS),
    .DEPTH(hbns_pkg::GRID_SIDE * hbns_pkg::GRID_SIDE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_ch.cell_z, in_ch.cell_x}),
    .wdata (in_ch.height_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hbns_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  hbns_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

endmodule

[hw/rtl/hbns_chk.sv]
// ----------------------------------------------------------------------------
// hbns_chk
// Port-level checks on the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbns_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic               out_accepted,
  input logic signed [23:0] out_height
);

  logic [1:0] pending;
  logic       in_xfer;
  logic       out_xfer;
  logic       out_unknown;
  logic       out_not_height;

  assign in_xfer        = in_valid && in_ready;
  assign out_xfer       = out_valid && out_ready;
  assign out_unknown    = out_valid && (out_kind == hbns_pkg::CMD_UNKNOWN);
  assign out_not_height = out_valid && (out_kind != hbns_pkg::CMD_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid after reset")
  `CHK_ASSERT(a_no_invented, clk, rst, out_valid |-> pending != 2'd0, "result without a command")
  `CHK_ASSERT(a_bounded, clk, rst, pending != 2'd3, "too many commands in flight")
  `CHK_ASSERT(a_unknown_rej, clk, rst, out_unknown |-> !out_accepted, "unknown command accepted")
  `CHK_ASSERT(a_height_zero, clk, rst, out_not_height |-> out_height == '0, "stray height")

endmodule

bind heightmap_bilinear_normal_sampler_unit hbns_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_accepted (out_ch.accepted),
  .out_height   (out_ch.height_out)
);

[test/tb_heightmap_bilinear_normal_sampler_unit.sv]
// ----------------------------------------------------------------------------
// tb_heightmap_bilinear_normal_sampler_unit
// Drives writes, height queries, normal queries and unknown commands under
// several grid and world size settings, predicts every result from a local
// copy of the height grid, and compares each transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heightmap_bilinear_normal_sampler_unit;

  typedef struct {
    logic [1:0]         command;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
    logic [7:0]         cell_x;
    logic [7:0]         cell_z;
    logic signed [23:0] height_in;
  } sample_cmd_t;

  typedef struct {
    logic [1:0]         kind;
    logic               accepted;
    logic signed [23:0] height_out;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } sample_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [hbns_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hbns_pkg::CFG_DATA_W-1:0] cfg_data;

  hbns_in_if in_ch ();
  hbns_out_if out_ch ();

  heightmap_bilinear_normal_sampler_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sample_cmd_t pending_cmds[$];
  sample_res_t expected_res[$];
  logic signed [23:0] grid_copy[hbns_pkg::GRID_SIDE*hbns_pkg::GRID_SIDE];
  bit grid_written[hbns_pkg::GRID_SIDE*hbns_pkg::GRID_SIDE];
  longint unsigned reg_points, reg_wx, reg_wz;
  int fail_count = 0;
  bit in_fired;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic longint eff_points();
    if (reg_points < 2) return 2;
    if (reg_points > hbns_pkg::GRID_SIDE) return hbns_pkg::GRID_SIDE;
    return reg_points;
  endfunction

  function automatic longint unsigned eff_size(longint unsigned w);
    return (w == 0) ? 1 : w;
  endfunction

  function automatic longint clamp_idx(longint v, longint n);
    if (v < 0) return 0;
    if (v > n - 1) return n - 1;
    return v;
  endfunction

  function automatic int cell_addr(longint x, longint z, longint n);
    return int'(clamp_idx(z, n) * hbns_pkg::GRID_SIDE + clamp_idx(x, n));
  endfunction

  function automatic longint grid_height(longint x, longint z, longint n);
    return longint'(grid_copy[cell_addr(x, z, n)]);
  endfunction

  function automatic longint grid_pos(longint p, longint unsigned ws, longint n);
    longint num, g, gmax;
    num = (2 * p + longint'(ws)) * (n - 1) * 4096;
    gmax = (n - 1) << hbns_pkg::HFRAC;
    if (num <= 0) return 0;
    g = num / longint'(2 * ws);
    return (g > gmax) ? gmax : g;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned slope_size(longint dh, longint n, longint unsigned ws);
    longint unsigned a;
    a = (dh < 0) ? longint'(-dh) : longint'(dh);
    return ((a * longint'(n - 1) << hbns_pkg::SFRAC) + ws / 2) / ws;
  endfunction

  // Applies one command to the local grid and returns the result it should produce.
  function automatic sample_res_t predict_sample(sample_cmd_t c);
    sample_res_t r;
    longint n, gx, gz, x0, z0, x1, z1, tx, tz, r0, r1, s, h, dx, dz;
    longint unsigned mag[3], top, sum, len;
    int a;
    n = eff_points();
    r = '{kind: c.command, accepted: 1'b1, height_out: '0,
          normal_x: '0, normal_y: '0, normal_z: '0};
    case (c.command)
      hbns_pkg::CMD_WRITE: begin
        if (c.cell_x < n && c.cell_z < n) begin
          a = int'(c.cell_z) * hbns_pkg::GRID_SIDE + int'(c.cell_x);
          grid_copy[a] = c.height_in;
          grid_written[a] = 1'b1;
        end else begin
          r.accepted = 1'b0;
        end
      end
      hbns_pkg::CMD_HEIGHT: begin
        gx = grid_pos(longint'(c.pos_x), eff_size(reg_wx), n);
        gz = grid_pos(longint'(c.pos_z), eff_size(reg_wz), n);
        x0 = gx >> hbns_pkg::HFRAC;
        z0 = gz >> hbns_pkg::HFRAC;
        tx = gx & 4095;
        tz = gz & 4095;
        x1 = (x0 + 1 > n - 1) ? n - 1 : x0 + 1;
        z1 = (z0 + 1 > n - 1) ? n - 1 : z0 + 1;
        r0 = grid_height(x0, z0, n) * (4096 - tx) + grid_height(x1, z0, n) * tx;
        r1 = grid_height(x0, z1, n) * (4096 - tx) + grid_height(x1, z1, n) * tx;
        s = r0 * (4096 - tz) + r1 * tz + (64'sd1 <<< 23);
        h = s >>> 24;
        if (h > 8388607) h = 8388607;
        if (h < -8388608) h = -8388608;
        r.height_out = h[23:0];
      end
      hbns_pkg::CMD_NORMAL: begin
        dx = grid_height(longint'(c.cell_x) + 2, c.cell_z, n)
           - grid_height(longint'(c.cell_x) - 2, c.cell_z, n);
        dz = grid_height(c.cell_x, longint'(c.cell_z) + 2, n)
           - grid_height(c.cell_x, longint'(c.cell_z) - 2, n);
        mag[0] = slope_size(dx, n, eff_size(reg_wx));
        mag[1] = 64'd4 << hbns_pkg::SFRAC;
        mag[2] = slope_size(dz, n, eff_size(reg_wz));
        top = mag[0];
        if (mag[1] > top) top = mag[1];
        if (mag[2] > top) top = mag[2];
        while (top >= (64'd1 << 30)) begin
          top >>= 1;
          foreach (mag[k]) mag[k] >>= 1;
        end
        while (top < (64'd1 << 29)) begin
          top <<= 1;
          foreach (mag[k]) mag[k] <<= 1;
        end
        sum = 0;
        foreach (mag[k]) sum += mag[k] * mag[k];
        len = int_sqrt(sum);
        foreach (mag[k]) mag[k] = (mag[k] * 16384 + len / 2) / len;
        r.normal_x = (dx > 0) ? -mag[0][15:0] : mag[0][15:0];
        r.normal_y = mag[1][15:0];
        r.normal_z = (dz > 0) ? -mag[2][15:0] : mag[2][15:0];
      end
      default: r.accepted = 1'b0;
    endcase
    return r;
  endfunction

  function automatic sample_cmd_t random_cmd(logic [1:0] command);
    sample_cmd_t c;
    c.command = command;
    c.pos_x = 24'($urandom);
    c.pos_z = 24'($urandom);
    c.cell_x = 8'($urandom);
    c.cell_z = 8'($urandom);
    c.height_in = 24'($urandom);
    return c;
  endfunction

  task automatic issue(sample_cmd_t c);
    expected_res.insert(expected_res.size(), predict_sample(c));
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic fill_cell(longint x, longint z, longint n);
    sample_cmd_t w;
    int a;
    a = cell_addr(x, z, n);
    if (!grid_written[a]) begin
      w = random_cmd(hbns_pkg::CMD_WRITE);
      w.cell_x = 8'(clamp_idx(x, n));
      w.cell_z = 8'(clamp_idx(z, n));
      if ($urandom_range(0, 3) == 0) w.height_in = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      issue(w);
    end
  endtask

  // Queries never read a cell that was never written, so missing cells are written first.
  task automatic issue_query(sample_cmd_t c);
    longint n, gx, gz, x0, z0;
    n = eff_points();
    if (c.command == hbns_pkg::CMD_HEIGHT) begin
      gx = grid_pos(longint'(c.pos_x), eff_size(reg_wx), n);
      gz = grid_pos(longint'(c.pos_z), eff_size(reg_wz), n);
      x0 = gx >> hbns_pkg::HFRAC;
      z0 = gz >> hbns_pkg::HFRAC;
      fill_cell(x0, z0, n);
      fill_cell(x0 + 1, z0, n);
      fill_cell(x0, z0 + 1, n);
      fill_cell(x0 + 1, z0 + 1, n);
    end else if (c.command == hbns_pkg::CMD_NORMAL) begin
      fill_cell(longint'(c.cell_x) + 2, c.cell_z, n);
      fill_cell(longint'(c.cell_x) - 2, c.cell_z, n);
      fill_cell(c.cell_x, longint'(c.cell_z) + 2, n);
      fill_cell(c.cell_x, longint'(c.cell_z) - 2, n);
    end
    issue(c);
  endtask

  function automatic logic signed [23:0] random_pos(longint unsigned ws);
    longint half, p;
    half = longint'(ws / 2);
    case ($urandom_range(0, 9))
      0: p = $urandom_range(0, 1) ? 8388607 : -8388608;
      1: p = $urandom_range(0, 1) ? half : -half;
      2: p = longint'(signed'(24'($urandom)));
      default: p = longint'($urandom_range(0, 2 * half + half / 4 + 1)) - half - half / 8;
    endcase
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[23:0];
  endfunction

  task automatic random_items(int count);
    sample_cmd_t c;
    int sel;
    longint n;
    n = eff_points();
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        c = random_cmd(hbns_pkg::CMD_WRITE);
        if ($urandom_range(0, 5) != 0) begin
          c.cell_x = 8'($urandom_range(0, n - 1));
          c.cell_z = 8'($urandom_range(0, n - 1));
        end
        issue(c);
      end else if (sel < 70) begin
        c = random_cmd(hbns_pkg::CMD_HEIGHT);
        c.pos_x = random_pos(eff_size(reg_wx));
        c.pos_z = random_pos(eff_size(reg_wz));
        issue_query(c);
      end else if (sel < 95) begin
        c = random_cmd(hbns_pkg::CMD_NORMAL);
        if ($urandom_range(0, 3) != 0) begin
          c.cell_x = 8'($urandom_range(0, n - 1));
          c.cell_z = 8'($urandom_range(0, n - 1));
        end
        issue_query(c);
      end else begin
        issue(random_cmd(hbns_pkg::CMD_UNKNOWN));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_res.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [hbns_pkg::CFG_IDX_W-1:0] idx, longint unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[hbns_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(longint unsigned pts, longint unsigned wx, longint unsigned wz);
    wait_idle();
    set_reg(hbns_pkg::CFG_GRID_POINTS, pts);
    set_reg(hbns_pkg::CFG_WORLD_X, wx);
    set_reg(hbns_pkg::CFG_WORLD_Z, wz);
    reg_points = pts & 9'h1FF;
    reg_wx = wx & 23'h7FFFFF;
    reg_wz = wz & 23'h7FFFFF;
  endtask

  task automatic directed_items();
    sample_cmd_t c;
    c = random_cmd(hbns_pkg::CMD_WRITE);
    c.cell_x = 8'd0; c.cell_z = 8'd0; c.height_in = 24'h7FFFFF;
    issue(c);
    c.cell_x = 8'd255; c.cell_z = 8'd255; c.height_in = 24'h800000;
    issue(c);
    c.cell_x = 8'd1; c.cell_z = 8'd0; c.height_in = 24'h800000;
    issue(c);
    c.cell_x = 8'd0; c.cell_z = 8'd1; c.height_in = 24'h800000;
    issue(c);
    c = random_cmd(hbns_pkg::CMD_HEIGHT);
    c.pos_x = 24'h800000; c.pos_z = 24'h800000;
    issue_query(c);
    c.pos_x = 24'h7FFFFF; c.pos_z = 24'h7FFFFF;
    issue_query(c);
    c.pos_x = '0; c.pos_z = '0;
    issue_query(c);
    c.pos_x = -24'sd32512; c.pos_z = 24'sd300;
    issue_query(c);
    c = random_cmd(hbns_pkg::CMD_NORMAL);
    c.cell_x = 8'd0; c.cell_z = 8'd0;
    issue_query(c);
    c.cell_x = 8'd255; c.cell_z = 8'd255;
    issue_query(c);
    c.cell_x = 8'd128; c.cell_z = 8'd3;
    issue_query(c);
    issue(random_cmd(hbns_pkg::CMD_UNKNOWN));
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Command driver: bursts of transfers separated by random gaps.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) in_fired <= in_ch.valid && in_ch.ready;

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fired) begin
    end else if (gap_left > 0 || pending_cmds.size() == 0) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else begin
      sample_cmd_t c;
      c = pending_cmds.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.command <= c.command;
      in_ch.pos_x <= c.pos_x;
      in_ch.pos_z <= c.pos_z;
      in_ch.cell_x <= c.cell_x;
      in_ch.cell_z <= c.cell_z;
      in_ch.height_in <= c.height_in;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 8);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Result receiver: stalls come in phases, with quiet stretches in between.
  int stall_left = 0;
  int phase_left = 0;
  bit stall_mode = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(100, 800);
        stall_mode <= $urandom_range(0, 2) != 0;
      end else begin
        phase_left <= phase_left - 1;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_mode && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(0, 20);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_res.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        sample_res_t e;
        e = expected_res.pop_front();
        check_field("kind", e.kind, out_ch.kind);
        check_field("accepted", e.accepted, out_ch.accepted);
        check_field("height_out", e.height_out, out_ch.height_out);
        check_field("normal_x", e.normal_x, out_ch.normal_x);
        check_field("normal_y", e.normal_y, out_ch.normal_y);
        check_field("normal_z", e.normal_z, out_ch.normal_z);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_points = hbns_pkg::GRID_POINTS_RST;
    reg_wx = hbns_pkg::WORLD_SIZE_RST;
    reg_wz = hbns_pkg::WORLD_SIZE_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_items();
    random_items(70);
    set_config(17, 3000, 500);
    begin
      sample_cmd_t c;
      c = random_cmd(hbns_pkg::CMD_WRITE);
      c.cell_x = 8'd200; c.cell_z = 8'd3;
      issue(c);
      c.cell_x = 8'd3; c.cell_z = 8'd16;
      issue(c);
      c.cell_x = 8'd17; c.cell_z = 8'd17;
      issue(c);
    end
    random_items(120);
    set_config(2, 1, 1);
    random_items(80);
    set_config(0, 0, 8388607);
    random_items(80);
    set_config(511, 8388607, 0);
    random_items(60);
    set_config(1, 40000, 40000);
    random_items(80);
    set_config(100, 256, 70000);
    random_items(60);
    set_config(256, 65280, 65280);
    random_items(60);

    wait_idle();
    repeat (400) @(posedge clk);
    if (fail_count == 0 && expected_res.size() == 0)
      $display("tb_heightmap_bilinear_normal_sampler_unit OK");
    else
      $display("tb_heightmap_bilinear_normal_sampler_unit NOT OK");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb_heightmap_bilinear_normal_sampler_unit NOT OK");
    $finish;
  end

endmodule
